// File: rtl/tdf_pkg.sv
// Shared types, constants and helpers for the two-hit diagonal filter.
// Used by tdf_update, two_hit_diagonal_filter and tb_top; depends on nothing.
`default_nettype none
package tdf_pkg;

  localparam int SEQ_SLOTS   = 4096;
  localparam int OFFSET_BITS = 15;
  localparam int SLOT_BITS   = $clog2(SEQ_SLOTS);
  localparam int EPOCH_BITS  = 8;

  localparam int DIAG_W  = 17;
  localparam int SUBJ_W  = 17;
  localparam int SEQ_W   = 12;
  localparam int QLEN_W  = 15;
  localparam int QOFF_W  = 16;
  localparam int HIT_W   = 32;
  localparam int CNT_W   = 16;
  localparam int PSLOT_W = 15;
  localparam int CFG_W   = 16;

  typedef logic [EPOCH_BITS-1:0] epoch_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;

  localparam epoch_t EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t EPOCH_LAST  = {EPOCH_BITS{1'b1}};
  localparam slot_t  SLOT_LAST   = slot_t'(SEQ_SLOTS - 1);

  // Register indexes of the configuration port.
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_WINDOW_A    = 2'd0;
  localparam reg_index_t REG_OVERLAP_MIN = 2'd1;
  localparam reg_index_t REG_QUERY_LEN   = 2'd2;
  localparam reg_index_t REG_MAX_PAIRS   = 2'd3;

  typedef enum logic [3:0] {
    ST_SWEEP = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CALC  = 4'b1000
  } state_t;

  // One table entry: an entry counts as valid only when its tag equals
  // the current epoch.
  typedef struct packed {
    epoch_t             tag;
    logic [CNT_W-1:0]   count;
    logic [HIT_W-1:0]   last;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] window_a;
    logic [CFG_W-1:0] overlap_min;
    logic [CFG_W-1:0] max_pairs;
  } cfg_t;

  typedef struct packed {
    logic   we;
    entry_t wdata;
  } update_t;

  typedef struct packed {
    logic               valid;
    logic [HIT_W-1:0]   first;
    logic [HIT_W-1:0]   second;
    logic [PSLOT_W-1:0] slot;
    logic               overflow;
  } result_t;

  function automatic slot_t slot_of(input logic [SEQ_W-1:0] sid);
    logic [31:0] wide;
    wide = 32'(sid);
    return wide[SLOT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/tdf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/tdf_update.sv
// Read-modify-write decision for one hit against its table entry.
// Depends on tdf_pkg.
`default_nettype none
module tdf_update (
  input  wire tdf_pkg::entry_t             rd_entry,
  input  wire logic [tdf_pkg::HIT_W-1:0]   cur_hit,
  input  wire tdf_pkg::epoch_t             epoch,
  input  wire tdf_pkg::cfg_t               cfg,
  output tdf_pkg::update_t                 upd,
  output tdf_pkg::result_t                 res
);

  logic                        entry_valid;
  logic [tdf_pkg::HIT_W-1:0]   gap;
  logic                        neg;
  logic                        far;
  logic                        pair_ok;
  logic [tdf_pkg::CNT_W:0]     cnt_plus;
  logic                        over;

  assign entry_valid = (rd_entry.tag == epoch);
  assign gap         = cur_hit - rd_entry.last;
  assign neg         = gap[tdf_pkg::HIT_W-1];
  assign far         = !neg && (gap >= tdf_pkg::HIT_W'(cfg.window_a));
  assign pair_ok     = !neg && (gap >= tdf_pkg::HIT_W'(cfg.overlap_min));
  assign cnt_plus    = {1'b0, rd_entry.count} + (tdf_pkg::CNT_W+1)'(2);
  assign over        = (cnt_plus > {1'b0, cfg.max_pairs});

  always_comb begin
    upd.we          = 1'b0;
    upd.wdata.tag   = epoch;
    upd.wdata.count = rd_entry.count;
    upd.wdata.last  = cur_hit;

    res.valid    = 1'b0;
    res.first    = rd_entry.last;
    res.second   = cur_hit;
    res.slot     = rd_entry.count[tdf_pkg::CNT_W-1:1];
    res.overflow = over;

    priority if (!entry_valid) begin
      // First hit of the sequence in this block: the count starts over.
      upd.we          = 1'b1;
      upd.wdata.count = '0;
    end else if (far) begin
      upd.we = 1'b1;
    end else if (pair_ok) begin
      upd.we    = 1'b1;
      res.valid = 1'b1;
      if (!over) begin
        upd.wdata.count = cnt_plus[tdf_pkg::CNT_W-1:0];
      end
    end else begin
      // Too close or behind the last hit: the entry stays as it is.
      upd.we = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/two_hit_diagonal_filter.sv
// Top level of the two-hit diagonal filter: control, config and the table.
// Depends on tdf_pkg, tdf_ram and tdf_update.
//
// Usage:
//   A hit (diagonal, subject_offset, seq_id, block_start) transfers at a
//   rising edge with start high and busy low. The per-sequence state is one
//   table RAM read at the transfer (again after a sweep) and written back
//   in the CALC state; busy stays high until then, so hits do not overlap.
//   A pair, when one forms, appears on pair_seq, first_hit, second_hit,
//   pair_slot and overflow with pair_valid high for exactly one cycle,
//   registered from the hit's CALC state. The receiver cannot stall it.
//   block_start advances an epoch tag, which empties every entry at once.
//   Once in 255 block starts the tag space runs out and a sweep of the
//   table (all 4096 entries, one entry a cycle) runs before that hit.
//   After reset the same sweep runs with busy high.
//   Configuration writes (wr_en, wr_index, wr_data) take effect at once and
//   are taken in every cycle, including during a sweep; change the
//   registers only while no hit is in flight.
`default_nettype none
module two_hit_diagonal_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tdf_pkg::DIAG_W-1:0]    diagonal,
  input  wire logic [tdf_pkg::SUBJ_W-1:0]    subject_offset,
  input  wire logic [tdf_pkg::SEQ_W-1:0]     seq_id,
  input  wire logic                          block_start,
  output logic                               pair_valid,
  output logic [tdf_pkg::SEQ_W-1:0]          pair_seq,
  output logic [tdf_pkg::HIT_W-1:0]          first_hit,
  output logic [tdf_pkg::HIT_W-1:0]          second_hit,
  output logic [tdf_pkg::PSLOT_W-1:0]        pair_slot,
  output logic                               overflow,
  input  wire logic                          wr_en,
  input  wire tdf_pkg::reg_index_t           wr_index,
  input  wire logic [tdf_pkg::CFG_W-1:0]     wr_data
);

  tdf_pkg::state_t                 state;
  tdf_pkg::epoch_t                 epoch;
  tdf_pkg::slot_t                  sweep_cnt;
  logic                            pending;
  logic [tdf_pkg::SEQ_W-1:0]       h_seq_id;
  tdf_pkg::slot_t                  h_slot;
  logic [tdf_pkg::HIT_W-1:0]       h_cur;

  logic [tdf_pkg::CFG_W-1:0]       window_a;
  logic [tdf_pkg::CFG_W-1:0]       overlap_min;
  logic [tdf_pkg::QLEN_W-1:0]      query_length;
  logic [tdf_pkg::CFG_W-1:0]       max_pairs;

  logic                            accept;
  logic [tdf_pkg::SUBJ_W-1:0]      qsum;
  logic [tdf_pkg::HIT_W-1:0]       cur_in;

  logic                            ram_we;
  tdf_pkg::slot_t                  ram_waddr;
  tdf_pkg::entry_t                 ram_wdata;
  tdf_pkg::slot_t                  ram_raddr;
  tdf_pkg::entry_t                 ram_rdata;

  tdf_pkg::cfg_t                   cfg;
  tdf_pkg::update_t                upd;
  tdf_pkg::result_t                res;

  assign busy   = (state != tdf_pkg::ST_IDLE);
  assign accept = start && (state == tdf_pkg::ST_IDLE);

  // Query offset wraps to 16 bits; the packed word wraps to 32 bits.
  assign qsum   = subject_offset - diagonal + tdf_pkg::SUBJ_W'(query_length);
  assign cur_in = (tdf_pkg::HIT_W'(diagonal) << tdf_pkg::OFFSET_BITS)
                + tdf_pkg::HIT_W'(qsum[tdf_pkg::QOFF_W-1:0]);

  assign cfg.window_a    = window_a;
  assign cfg.overlap_min = overlap_min;
  assign cfg.max_pairs   = max_pairs;

  assign ram_raddr = (state == tdf_pkg::ST_IDLE) ? tdf_pkg::slot_of(seq_id) : h_slot;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = h_slot;
    ram_wdata = upd.wdata;
    unique case (state)
      tdf_pkg::ST_SWEEP: begin
        // Tag zero never matches a live epoch, so the entry reads as empty.
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt;
        ram_wdata = '0;
      end
      tdf_pkg::ST_CALC: begin
        ram_we = upd.we;
      end
      tdf_pkg::ST_IDLE, tdf_pkg::ST_READ: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tdf_ram #(
    .WIDTH ($bits(tdf_pkg::entry_t)),
    .DEPTH (tdf_pkg::SEQ_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  tdf_update u_update (
    .rd_entry (ram_rdata),
    .cur_hit  (h_cur),
    .epoch    (epoch),
    .cfg      (cfg),
    .upd      (upd),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tdf_pkg::ST_SWEEP;
      epoch      <= tdf_pkg::EPOCH_FIRST;
      sweep_cnt  <= '0;
      pending    <= 1'b0;
      pair_valid <= 1'b0;
    end else begin
      pair_valid <= 1'b0;
      unique case (state)
        tdf_pkg::ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + tdf_pkg::slot_t'(1);
          if (sweep_cnt == tdf_pkg::SLOT_LAST) begin
            epoch   <= tdf_pkg::EPOCH_FIRST;
            pending <= 1'b0;
            state   <= pending ? tdf_pkg::ST_READ : tdf_pkg::ST_IDLE;
          end
        end
        tdf_pkg::ST_IDLE: begin
          if (accept) begin
            if (block_start && (epoch == tdf_pkg::EPOCH_LAST)) begin
              sweep_cnt <= '0;
              pending   <= 1'b1;
              state     <= tdf_pkg::ST_SWEEP;
            end else begin
              if (block_start) begin
                epoch <= epoch + tdf_pkg::epoch_t'(1);
              end
              state <= tdf_pkg::ST_CALC;
            end
          end
        end
        tdf_pkg::ST_READ: begin
          state <= tdf_pkg::ST_CALC;
        end
        tdf_pkg::ST_CALC: begin
          pair_valid <= res.valid;
          state      <= tdf_pkg::ST_IDLE;
        end
        default: begin
          state <= tdf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Hit hold registers and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      h_seq_id <= seq_id;
      h_slot   <= tdf_pkg::slot_of(seq_id);
      h_cur    <= cur_in;
    end
    if (state == tdf_pkg::ST_CALC) begin
      pair_seq   <= h_seq_id;
      first_hit  <= res.first;
      second_hit <= res.second;
      pair_slot  <= res.slot;
      overflow   <= res.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_a     <= tdf_pkg::CFG_W'(40);
      overlap_min  <= tdf_pkg::CFG_W'(3);
      query_length <= tdf_pkg::QLEN_W'(1);
      max_pairs    <= tdf_pkg::CFG_W'(64);
    end else if (wr_en) begin
      unique case (wr_index)
        tdf_pkg::REG_WINDOW_A:    window_a     <= wr_data;
        tdf_pkg::REG_OVERLAP_MIN: overlap_min  <= wr_data;
        tdf_pkg::REG_QUERY_LEN:   query_length <= wr_data[tdf_pkg::QLEN_W-1:0];
        tdf_pkg::REG_MAX_PAIRS:   max_pairs    <= wr_data;
        default:                  window_a     <= window_a;
      endcase
    end
  end

  a_pair_from_calc: assert property (@(posedge clk) disable iff (rst)
    pair_valid |-> $past(state == tdf_pkg::ST_CALC))
    else $error("pair strobe without a preceding table update");

  a_accept_moves_on: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == tdf_pkg::ST_CALC || state == tdf_pkg::ST_SWEEP))
    else $error("accepted hit did not start its table access");

  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("epoch reached the tag reserved for empty entries");

  a_no_pair_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == tdf_pkg::ST_SWEEP) |-> !pair_valid)
    else $error("pair strobe during a table sweep");

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_hit_diagonal_filter: directed hits, then
// random phases under several register settings. Depends on tdf_pkg and the RTL.
module tb_top;
  import tdf_pkg::*;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [HIT_W-1:0]   first;
    logic [HIT_W-1:0]   second;
    logic [PSLOT_W-1:0] slot;
    logic               ovf;
  } pair_t;

  typedef enum logic [0:0] {ROW_HIT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    reg_index_t        ridx;
    logic [CFG_W-1:0]  rval;
    logic [DIAG_W-1:0] diag;
    logic [SUBJ_W-1:0] subj;
    logic [SEQ_W-1:0]  seq;
    logic              bs;
    logic              typed;
    pair_t             want;
  } dir_row_t;

  typedef struct {
    int wa;
    int om;
    int ql;
    int mp;
    int items;
    int idle_pct;
    int npool;
    bit churn;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [DIAG_W-1:0] diagonal = '0;
  logic [SUBJ_W-1:0] subject_offset = '0;
  logic [SEQ_W-1:0] seq_id = '0;
  logic block_start = 1'b0;
  logic pair_valid;
  logic [SEQ_W-1:0] pair_seq;
  logic [HIT_W-1:0] first_hit;
  logic [HIT_W-1:0] second_hit;
  logic [PSLOT_W-1:0] pair_slot;
  logic overflow;
  logic wr_en = 1'b0;
  reg_index_t wr_index = REG_WINDOW_A;
  logic [CFG_W-1:0] wr_data = '0;

  // Shadow registers, reset values.
  logic [CFG_W-1:0]  cfg_window = 16'd40;
  logic [CFG_W-1:0]  cfg_overlap = 16'd3;
  logic [QLEN_W-1:0] cfg_qlen = 15'd1;
  logic [CFG_W-1:0]  cfg_maxp = 16'd64;

  // Predicted per-sequence state.
  logic [HIT_W-1:0] last_word [SEQ_SLOTS];
  bit               word_valid [SEQ_SLOTS];
  logic [CNT_W-1:0] stored_words [SEQ_SLOTS];

  pair_t pending_pairs [$];
  pair_t got_want;
  int errors = 0;
  int pairs_checked = 0;
  int overflow_seen = 0;
  int hits_sent = 0;
  int settings_used = 0;

  dir_row_t dir_rows [23] = '{
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd0, 12'd0, 1'b1, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd5, 12'd0, 1'b0, 1'b1,
      '{12'd0, 32'd1, 32'd6, 15'd0, 1'b0}},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd6, 12'd0, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd100, 12'd0, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd50, 12'd0, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd131071, 17'd131071, 12'd4095, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd131071, 17'd32765, 12'd4095, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd3, 12'd4095, 1'b0, 1'b1,
      '{12'd4095, 32'hffff_ffff, 32'd4, 15'd0, 1'b0}},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd131071, 12'd2048, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd1, 17'd0, 12'd2048, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_MAX_PAIRS, 16'd2, 17'd0, 17'd0, 12'd0, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd10, 12'd7, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd20, 12'd7, 1'b0, 1'b1,
      '{12'd7, 32'd11, 32'd21, 15'd0, 1'b0}},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd30, 12'd7, 1'b0, 1'b1,
      '{12'd7, 32'd21, 32'd31, 15'd1, 1'b1}},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd40, 12'd7, 1'b0, 1'b1,
      '{12'd7, 32'd31, 32'd41, 15'd1, 1'b1}},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd50, 12'd7, 1'b1, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd55, 12'd7, 1'b0, 1'b1,
      '{12'd7, 32'd51, 32'd56, 15'd0, 1'b0}},
    '{ROW_CFG, REG_WINDOW_A, 16'd65535, 17'd0, 17'd0, 12'd0, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_OVERLAP_MIN, 16'd0, 17'd0, 17'd0, 12'd0, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd0, 17'd55, 12'd7, 1'b0, 1'b1,
      '{12'd7, 32'd56, 32'd56, 15'd1, 1'b1}},
    '{ROW_CFG, REG_QUERY_LEN, 16'd32767, 17'd0, 17'd0, 12'd0, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd100, 17'd100, 12'd7, 1'b0, 1'b0, '0},
    '{ROW_HIT, REG_WINDOW_A, 16'd0, 17'd100, 17'd200, 12'd7, 1'b0, 1'b0, '0}
  };

  phase_t phase_plan [7] = '{
    '{40, 3, 1, 64, 160, 0, 6, 1'b0},
    '{65535, 0, 32767, 2, 180, 63, 4, 1'b0},
    '{0, 0, 100, 65535, 50, 0, 4, 1'b0},
    '{300, 65535, 1, 64, 50, 17, 4, 1'b0},
    '{16, 1, 5000, 6, 160, 17, 3, 1'b0},
    '{64, 2, 32767, 4, 400, 63, 2, 1'b1},
    '{1000, 5, 77, 200, 120, 0, 5, 1'b0}
  };

  two_hit_diagonal_filter dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .diagonal       (diagonal),
    .subject_offset (subject_offset),
    .seq_id         (seq_id),
    .block_start    (block_start),
    .pair_valid     (pair_valid),
    .pair_seq       (pair_seq),
    .first_hit      (first_hit),
    .second_hit     (second_hit),
    .pair_slot      (pair_slot),
    .overflow       (overflow),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d pairs outstanding", $time, pending_pairs.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Returns 1 when the hit forms a pair; updates the predicted tables.
  function automatic bit predict_pair(input logic [DIAG_W-1:0] d,
                                      input logic [SUBJ_W-1:0] s,
                                      input logic [SEQ_W-1:0] sid,
                                      input logic bs,
                                      output pair_t p);
    logic [31:0] sum;
    logic [HIT_W-1:0] cur;
    logic [HIT_W-1:0] gap;
    logic [CNT_W-1:0] cnt;
    logic over;
    int idx;
    p = '0;
    if (bs) begin
      foreach (word_valid[i]) begin
        word_valid[i] = 1'b0;
        stored_words[i] = '0;
      end
    end
    idx = int'(sid) % SEQ_SLOTS;
    sum = 32'(s) - 32'(d) + 32'(cfg_qlen);
    cur = (32'(d) << OFFSET_BITS) + 32'(sum[QOFF_W-1:0]);
    if (!word_valid[idx]) begin
      last_word[idx] = cur;
      word_valid[idx] = 1'b1;
      return 1'b0;
    end
    gap = cur - last_word[idx];
    // A negative distance falls below both thresholds and changes nothing.
    if (gap[31])
      return 1'b0;
    if (gap >= 32'(cfg_window)) begin
      last_word[idx] = cur;
      return 1'b0;
    end
    if (gap < 32'(cfg_overlap))
      return 1'b0;
    cnt = stored_words[idx];
    over = (32'(cnt) + 32'd2) > 32'(cfg_maxp);
    if (!over)
      stored_words[idx] = cnt + 16'd2;
    p.seq = sid;
    p.first = last_word[idx];
    p.second = cur;
    p.slot = PSLOT_W'(cnt >> 1);
    p.ovf = over;
    last_word[idx] = cur;
    return 1'b1;
  endfunction

  task automatic send_hit(input logic [DIAG_W-1:0] d, input logic [SUBJ_W-1:0] s,
                          input logic [SEQ_W-1:0] sid, input logic bs,
                          input logic typed, input pair_t want);
    pair_t p;
    bit formed;
    start <= 1'b1;
    diagonal <= d;
    subject_offset <= s;
    seq_id <= sid;
    block_start <= bs;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    hits_sent++;
    formed = predict_pair(d, s, sid, bs, p);
    if (typed)
      pending_pairs.push_back(want);
    else if (formed)
      pending_pairs.push_back(p);
  endtask

  // Leaves the filter with nothing in flight; a hit may still be waiting on
  // a table sweep, so busy has to drop before the pairs drain.
  task automatic settle_hits();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_pairs.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Leaves wr_en high; the caller lowers it after the last write.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      REG_WINDOW_A:    cfg_window = val;
      REG_OVERLAP_MIN: cfg_overlap = val;
      REG_QUERY_LEN:   cfg_qlen = val[QLEN_W-1:0];
      REG_MAX_PAIRS:   cfg_maxp = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && pair_valid) begin
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: pair with none expected: seq=%0d first=%h second=%h slot=%0d ovf=%0b",
                 $time, pair_seq, first_hit, second_hit, pair_slot, overflow);
      end else begin
        got_want = pending_pairs.pop_front();
        pairs_checked++;
        if (overflow === 1'b1)
          overflow_seen++;
        if (pair_seq !== got_want.seq) begin
          errors++;
          $display("%0t: pair_seq expected %0d actual %0d", $time, got_want.seq, pair_seq);
        end
        if (first_hit !== got_want.first) begin
          errors++;
          $display("%0t: first_hit expected %h actual %h", $time, got_want.first, first_hit);
        end
        if (second_hit !== got_want.second) begin
          errors++;
          $display("%0t: second_hit expected %h actual %h", $time, got_want.second,
                   second_hit);
        end
        if (pair_slot !== got_want.slot) begin
          errors++;
          $display("%0t: pair_slot expected %0d actual %0d", $time, got_want.slot, pair_slot);
        end
        if (overflow !== got_want.ovf) begin
          errors++;
          $display("%0t: overflow expected %0b actual %0b", $time, got_want.ovf, overflow);
        end
      end
    end
  end

  initial begin
    logic [DIAG_W-1:0] diag_cur [8];
    logic [SUBJ_W-1:0] subj_cur [8];
    logic [SEQ_W-1:0]  seq_pool [8];
    logic [DIAG_W-1:0] d;
    logic [SUBJ_W-1:0] s;
    logic [SEQ_W-1:0]  sid;
    logic              bs;
    int r;
    int k;
    int span;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows run with the reset settings until a row rewrites one.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle_hits();
        write_reg(dir_rows[i].ridx, dir_rows[i].rval);
        wr_en <= 1'b0;
        settings_used++;
      end else begin
        send_hit(dir_rows[i].diag, dir_rows[i].subj, dir_rows[i].seq, dir_rows[i].bs,
                 dir_rows[i].typed, dir_rows[i].want);
      end
    end

    foreach (phase_plan[ph]) begin
      settle_hits();
      write_reg(REG_WINDOW_A, CFG_W'(phase_plan[ph].wa));
      write_reg(REG_OVERLAP_MIN, CFG_W'(phase_plan[ph].om));
      write_reg(REG_QUERY_LEN, CFG_W'(phase_plan[ph].ql));
      write_reg(REG_MAX_PAIRS, CFG_W'(phase_plan[ph].mp));
      wr_en <= 1'b0;
      settings_used++;
      for (int j = 0; j < 8; j++) begin
        diag_cur[j] = DIAG_W'($urandom);
        subj_cur[j] = SUBJ_W'($urandom);
        seq_pool[j] = SEQ_W'($urandom);
      end
      for (int n = 0; n < phase_plan[ph].items; n++) begin
        if ($urandom_range(0, 99) < phase_plan[ph].idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        r = $urandom_range(0, 99);
        k = $urandom_range(0, phase_plan[ph].npool - 1);
        span = int'(cfg_window) + int'(cfg_window) / 4 + 8;
        if (span > 65535)
          span = 65535;
        if (r < 65) begin
          // Step forward along the same diagonal, mostly inside the window.
          subj_cur[k] = SUBJ_W'(subj_cur[k] + $urandom_range(0, span));
        end else if (r < 75) begin
          diag_cur[k] = DIAG_W'($urandom);
          subj_cur[k] = SUBJ_W'($urandom);
        end else if (r < 85) begin
          subj_cur[k] = SUBJ_W'(subj_cur[k] - $urandom_range(1, 64));
        end
        if (r < 85) begin
          d = diag_cur[k];
          s = subj_cur[k];
          sid = seq_pool[k];
        end else begin
          d = DIAG_W'($urandom);
          s = SUBJ_W'($urandom);
          sid = SEQ_W'($urandom);
        end
        // The churn phase starts many blocks so the epoch tags wrap around.
        if (phase_plan[ph].churn)
          bs = $urandom_range(0, 7) < 5;
        else
          bs = $urandom_range(0, 15) == 0;
        send_hit(d, s, sid, bs, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_pairs.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d hits under %0d register settings.", hits_sent, settings_used);
    $display("Checked %0d pairs, %0d of them with overflow set.", pairs_checked,
             overflow_seen);
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tdf_pkg.sv
rtl/tdf_ram.sv
rtl/tdf_update.sv
rtl/two_hit_diagonal_filter.sv
sim/tb_top.sv
